// ===== hw/rtl/mcpg_pkg.sv =====
// shared types and constants for the midpoint circle point generator
package mcpg_pkg;

  localparam int unsigned CoordW    = 12;
  localparam int unsigned RadiusW   = 10;
  localparam int unsigned OffsetW   = 11;
  localparam int unsigned DecisionW = 14;
  localparam int unsigned PointW    = 13;
  localparam int unsigned InDataW   = 40;
  localparam int unsigned OutDataW  = 32;
  localparam int unsigned NumPoints = 8;
  localparam int unsigned IdxW      = 3;

  typedef enum logic {
    CmdStart = 1'b0,
    CmdStep  = 1'b1
  } cmd_e;

  // one queued octant step: center, offsets before the step, finish flag
  typedef struct packed {
    logic signed [CoordW-1:0]  cx;
    logic signed [CoordW-1:0]  cy;
    logic signed [OffsetW-1:0] ox;
    logic signed [OffsetW-1:0] oy;
    logic                      done;
  } step_t;

  // queue status seen by the front
  typedef struct packed {
    logic full;
  } q_stat_t;

endpackage

// ===== hw/rtl/mcpg_front.sv =====
// front part: accepts commands, holds the circle state and queues steps
module mcpg_front import mcpg_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [InDataW-1:0]  in_data_i,
  input  logic                in_user_i,
  input  q_stat_t             q_stat_i,
  output logic                push_o,
  output step_t               push_data_o
);

  logic signed [OffsetW-1:0]   ox_q, ox_d, oy_q, oy_d;
  logic signed [DecisionW-1:0] dec_q, dec_d;
  logic signed [CoordW-1:0]    cx_q, cx_d, cy_q, cy_d;
  logic                        active_q, active_d;

  logic                        accept;
  cmd_e                        cmd;
  logic [RadiusW-1:0]          radius;
  logic signed [DecisionW-1:0] ox_ext, oy_ext, rad_ext;
  logic signed [OffsetW-1:0]   ox_inc;
  logic                        done;

  assign in_ready_o = !q_stat_i.full;
  assign accept     = in_valid_i && in_ready_o;
  assign cmd        = cmd_e'(in_user_i);
  assign radius     = in_data_i[2*CoordW +: RadiusW];

  assign ox_ext  = DecisionW'(ox_q);
  assign oy_ext  = DecisionW'(oy_q);
  assign rad_ext = DecisionW'(signed'({1'b0, radius}));
  assign ox_inc  = ox_q + OffsetW'(1);

  always_comb begin
    ox_d     = ox_q;
    oy_d     = oy_q;
    dec_d    = dec_q;
    cx_d     = cx_q;
    cy_d     = cy_q;
    active_d = active_q;
    done     = 1'b0;
    push_o   = 1'b0;
    if (accept) begin
      if (cmd == CmdStart) begin
        cx_d     = in_data_i[0 +: CoordW];
        cy_d     = in_data_i[CoordW +: CoordW];
        ox_d     = '0;
        oy_d     = OffsetW'(signed'({1'b0, radius}));
        dec_d    = DecisionW'(3) - (rad_ext <<< 1);
        active_d = 1'b1;
      end else if (active_q) begin
        // decision update uses the offsets from before the step
        if (dec_q < 0) begin
          dec_d = dec_q + (ox_ext <<< 2) + DecisionW'(6);
        end else begin
          dec_d = dec_q + ((ox_ext - oy_ext) <<< 2) + DecisionW'(10);
          oy_d  = oy_q - OffsetW'(1);
        end
        ox_d   = ox_inc;
        done   = ox_inc > oy_d;
        push_o = 1'b1;
        if (done) begin
          active_d = 1'b0;
        end
      end
    end
  end

  assign push_data_o = '{cx: cx_q, cy: cy_q, ox: ox_q, oy: oy_q, done: done};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ox_q     <= '0;
      oy_q     <= '0;
      dec_q    <= '0;
      cx_q     <= '0;
      cy_q     <= '0;
      active_q <= 1'b0;
    end else begin
      ox_q     <= ox_d;
      oy_q     <= oy_d;
      dec_q    <= dec_d;
      cx_q     <= cx_d;
      cy_q     <= cy_d;
      active_q <= active_d;
    end
  end

endmodule

// ===== hw/rtl/mcpg_queue.sv =====
// short step queue between front and back
module mcpg_queue import mcpg_pkg::*; #(
  parameter int unsigned Depth = 2
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  step_t   push_data_i,
  output q_stat_t stat_o,
  output logic    valid_o,
  input  logic    pop_i,
  output step_t   data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  step_t           slots_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  assign stat_o.full = (count_q == CntW'(Depth));
  assign valid_o     = (count_q != '0);
  assign data_o      = slots_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

// ===== hw/rtl/mcpg_back.sv =====
// back part: expands one queued step into eight points, one per cycle while the output is not stalled
module mcpg_back import mcpg_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_valid_i,
  input  step_t               q_data_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [OutDataW-1:0] out_data_o,
  output logic                out_last_o,
  output logic                out_user_o
);

  localparam logic [IdxW-1:0] LastIdx = IdxW'(NumPoints - 1);

  step_t                    cur_q;
  logic                     busy_q;
  logic [IdxW-1:0]          idx_q;
  logic                     out_valid_q;
  logic signed [PointW-1:0] px_q, py_q;
  logic                     last_q, done_q;

  logic                     adv;
  logic signed [OffsetW-1:0] ua, ub;
  logic signed [PointW-1:0] ea, eb, cxe, cye, px_d, py_d;

  assign adv   = busy_q && (!out_valid_q || out_ready_i);
  assign pop_o = q_valid_i && (!busy_q || (adv && idx_q == LastIdx));

  // bit 2 swaps the offsets, bit 1 negates the x term, bit 0 the y term
  always_comb begin
    ua   = idx_q[2] ? cur_q.oy : cur_q.ox;
    ub   = idx_q[2] ? cur_q.ox : cur_q.oy;
    ea   = PointW'(ua);
    eb   = PointW'(ub);
    cxe  = PointW'(cur_q.cx);
    cye  = PointW'(cur_q.cy);
    px_d = idx_q[1] ? (cxe - ea) : (cxe + ea);
    py_d = idx_q[0] ? (cye - eb) : (cye + eb);
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q <= q_data_i;
    end
    if (adv) begin
      px_q   <= px_d;
      py_q   <= py_d;
      last_q <= (idx_q == LastIdx);
      done_q <= cur_q.done;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (adv) begin
        out_valid_q <= 1'b1;
        idx_q       <= idx_q + 1'b1;
        if (idx_q == LastIdx) begin
          busy_q <= 1'b0;
        end
      end
      if (pop_o) begin
        busy_q <= 1'b1;
        idx_q  <= '0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = OutDataW'({py_q, px_q});
  assign out_last_o  = last_q;
  assign out_user_o  = done_q;

`ifndef SYNTHESIS
  a_pop_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> (busy_q && idx_q == '0))
    else $error("step load did not restart the point counter");
  a_last_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && idx_q == LastIdx) |=> (out_valid_q && last_q))
    else $error("eighth point not marked last");
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && !adv) |-> !pop_o)
    else $error("new step loaded while a step is still expanding");
`endif

endmodule

// ===== hw/rtl/midpoint_circle_point_generator_unit.sv =====
// top level of the midpoint circle point generator
// usage:
//   slave stream carries commands: tuser = cmd (start or step), tdata holds
//   center_x, center_y and radius; only start uses the payload
//   a start transfer loads center and radius and produces nothing
//   a step transfer produces eight point transfers on the master stream,
//   tlast on the eighth, tuser set on all eight when the step ends the circle
//   a step while no circle runs is taken and dropped
// path: the first point of a step reaches the master side through the queue
//   slot, the back part's step register and then the point output register
// throughput: one point per cycle while the receiver does not stall, set by
//   the single point generator in the back part
// the front keeps accepting while the back expands a step, up to QueueDepth
//   steps waiting in the queue; when the receiver stalls the output register
//   holds its point, the back stops, then the queue fills and tready drops
// reset: no circle active, queue empty, master tvalid low
module midpoint_circle_point_generator_unit import mcpg_pkg::*; #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,   // center_x[11:0], center_y[23:12], radius[33:24]
  input  logic                s_axis_tuser,   // cmd
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,   // point_x[12:0], point_y[25:13]
  output logic                m_axis_tlast,   // last_of_step
  output logic                m_axis_tuser    // circle_done
);

  // front to queue
  logic    push;
  step_t   push_data;
  q_stat_t q_stat;

  // queue to back
  logic    q_valid;
  logic    pop;
  step_t   q_data;

  mcpg_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_data_i   (s_axis_tdata),
    .in_user_i   (s_axis_tuser),
    .q_stat_i    (q_stat),
    .push_o      (push),
    .push_data_o (push_data)
  );

  mcpg_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .stat_o      (q_stat),
    .valid_o     (q_valid),
    .pop_i       (pop),
    .data_o      (q_data)
  );

  mcpg_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_data_i    (q_data),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast),
    .out_user_o  (m_axis_tuser)
  );

endmodule
